// File: design/rrle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rrle_pkg;

    localparam logic [7:0] HDR_DUP   = 8'h80;
    localparam logic [7:0] HDR_LIT   = 8'hC0;
    localparam int         DUP_CHUNK = 64;
    localparam int         Q_DEPTH   = 4;

    // one queued step: window bytes, how many are valid, row/block end flags
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] fill;
        logic       row_end;
        logic       last;
    } rrle_cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ZERO = 2'd1,
        MODE_DUP  = 2'd2,
        MODE_LIT  = 2'd3
    } rrle_mode_t;

endpackage
`default_nettype wire

// File: design/rrle_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rrle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// File: design/rrle_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module rrle_fifo
    import rrle_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire rrle_cmd_t push_data,
    output logic           full,
    input  wire logic      pop,
    output rrle_cmd_t      pop_data,
    output logic           empty
);
    localparam int AW = $clog2(Q_DEPTH);

    rrle_cmd_t         mem_reg [Q_DEPTH];
    logic [AW-1:0]     wp_reg, rp_reg;
    logic [AW:0]       cnt_reg;

    assign full     = (cnt_reg == (AW+1)'(Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end
endmodule
`default_nettype wire

// File: design/rrle_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rrle_front
    import rrle_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] row_bytes,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_of_block,
    output logic             q_push,
    output rrle_cmd_t        q_data,
    input  wire logic        q_full
);
    logic [7:0]  w0_reg, w1_reg;
    logic [1:0]  fill_reg;
    logic [15:0] pos_reg;
    logic        accept, row_end;
    logic [16:0] row_len, pos_inc;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign row_len  = (row_bytes == 16'd0) ? 17'h10000 : {1'b0, row_bytes};
    assign pos_inc  = {1'b0, pos_reg} + 17'd1;
    assign row_end  = last_of_block || (pos_inc >= row_len);

    always_comb
    begin
        q_data.b0      = (fill_reg == 2'd0) ? data_byte : w0_reg;
        q_data.b1      = (fill_reg == 2'd1) ? data_byte : w1_reg;
        q_data.b2      = data_byte;
        q_data.fill    = fill_reg + 2'd1;
        q_data.row_end = row_end;
        q_data.last    = last_of_block;
        q_push         = accept && (row_end || fill_reg == 2'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg   <= '0;
            w1_reg   <= '0;
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else if (accept)
        begin
            if (row_end)
            begin
                fill_reg <= '0;
                pos_reg  <= '0;
            end
            else
            begin
                pos_reg <= pos_inc[15:0];
                if (fill_reg == 2'd2)
                begin
                    w0_reg <= w1_reg;
                    w1_reg <= data_byte;
                end
                else if (fill_reg == 2'd0)
                begin
                    w0_reg   <= data_byte;
                    fill_reg <= 2'd1;
                end
                else
                begin
                    w1_reg   <= data_byte;
                    fill_reg <= 2'd2;
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: design/rrle_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rrle_back
    import rrle_pkg::*;
#(
    parameter int LITERAL_CHUNK = 64,
    parameter int ZERO_CHUNK    = 128,
    parameter int WORD_BYTES    = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    input  wire rrle_cmd_t   q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      out_word,
    output logic [3:0]       byte_count,
    output logic             end_of_block
);
    localparam int AW = $clog2(LITERAL_CHUNK);

    typedef enum logic [6:0] {
        ST_POP   = 7'b0000001,
        ST_STEP  = 7'b0000010,
        ST_CLOSE = 7'b0000100,
        ST_EMIT  = 7'b0001000,
        ST_LRD   = 7'b0010000,
        ST_LWR   = 7'b0100000,
        ST_END   = 7'b1000000
    } state_t;

    state_t     state_reg, state_next, ret_reg, ret_next;
    rrle_cmd_t  cmd_reg, cmd_next;
    rrle_mode_t mode_reg, mode_next;
    logic [1:0] k_reg, k_next;
    logic [7:0] rv_reg, rv_next, rl_reg, rl_next;
    logic [6:0] lc_reg, lc_next, lit_len_reg, lit_len_next, j_reg, j_next;
    logic [1:0] pend_cnt_reg, pend_cnt_next;
    logic [7:0] pend0_reg, pend0_next, pend1_reg, pend1_next;
    logic       lit_pend_reg, lit_pend_next;
    logic [63:0] buf_reg, buf_next;
    logic [3:0]  pcount_reg, pcount_next;
    logic        ov_reg, ov_next, eob_reg, eob_next;
    logic [63:0] ow_reg, ow_next;
    logic [3:0]  oc_reg, oc_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic       emit_req, emit_ok, out_free, push_req, push_eob, done, stop, h1;
    logic [7:0] emit_byte, b, n1;
    logic [8:0] rl_inc;
    logic [6:0] lc_inc;
    state_t     target;

    rrle_ram #(.WIDTH(8), .DEPTH(LITERAL_CHUNK)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid    = ov_reg;
    assign out_word     = ow_reg;
    assign byte_count   = oc_reg;
    assign end_of_block = eob_reg;
    assign out_free     = !ov_reg || !out_stall;
    assign emit_ok      = (pcount_reg != 4'(WORD_BYTES)) || out_free;

    always_comb
    begin
        case (k_reg)
            2'd0:    begin b = cmd_reg.b0; n1 = cmd_reg.b1; end
            2'd1:    begin b = cmd_reg.b1; n1 = cmd_reg.b2; end
            default: begin b = cmd_reg.b2; n1 = 8'd0;       end
        endcase
        h1     = !cmd_reg.row_end || ((k_reg + 2'd1) < cmd_reg.fill);
        stop   = !cmd_reg.row_end &&
                 ((b == 8'd0 && n1 == 8'd0) || (b == n1 && n1 == cmd_reg.b2));
        rl_inc = {1'b0, rl_reg} + 9'd1;
        lc_inc = lc_reg + 7'd1;
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cmd_next      = cmd_reg;
        mode_next     = mode_reg;
        k_next        = k_reg;
        rv_next       = rv_reg;
        rl_next       = rl_reg;
        lc_next       = lc_reg;
        lit_len_next  = lit_len_reg;
        j_next        = j_reg;
        pend_cnt_next = pend_cnt_reg;
        pend0_next    = pend0_reg;
        pend1_next    = pend1_reg;
        lit_pend_next = lit_pend_reg;
        ram_we        = 1'b0;
        ram_waddr     = lc_reg[AW-1:0];
        ram_wdata     = b;
        ram_re        = 1'b0;
        ram_raddr     = j_reg[AW-1:0];
        emit_req      = 1'b0;
        emit_byte     = pend0_reg;
        q_pop         = 1'b0;
        push_req      = 1'b0;
        push_eob      = 1'b0;
        done          = 1'b0;
        target        = ST_STEP;

        unique case (state_reg)
            ST_POP:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    k_next     = 2'd0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP, ST_CLOSE:
            begin
                unique case (mode_reg)
                    MODE_ZERO:
                    begin
                        if (state_reg == ST_STEP && b == 8'd0)
                        begin
                            done = 1'b1;
                            if (rl_inc >= 9'(ZERO_CHUNK))
                            begin
                                pend0_next    = {1'b0, rl_inc[6:0]};
                                pend_cnt_next = 2'd1;
                                rl_next       = '0;
                            end
                            else
                            begin
                                rl_next = rl_inc[7:0];
                            end
                        end
                        else
                        begin
                            if (rl_reg != 8'd0)
                            begin
                                pend0_next    = {1'b0, rl_reg[6:0]};
                                pend_cnt_next = 2'd1;
                            end
                            mode_next = MODE_IDLE;
                            rl_next   = '0;
                        end
                    end
                    MODE_DUP:
                    begin
                        if (state_reg == ST_STEP && b == rv_reg)
                        begin
                            done = 1'b1;
                            if (rl_inc >= 9'(DUP_CHUNK))
                            begin
                                pend0_next    = HDR_DUP | {2'b00, rl_inc[5:0]};
                                pend1_next    = rv_reg;
                                pend_cnt_next = 2'd2;
                                rl_next       = '0;
                            end
                            else
                            begin
                                rl_next = rl_inc[7:0];
                            end
                        end
                        else
                        begin
                            if (rl_reg >= 8'd2)
                            begin
                                pend0_next    = HDR_DUP | {2'b00, rl_reg[5:0]};
                                pend1_next    = rv_reg;
                                pend_cnt_next = 2'd2;
                                mode_next     = MODE_IDLE;
                            end
                            else if (rl_reg == 8'd1)
                            begin
                                // lone leftover duplicate opens a literal run
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = rv_reg;
                                lc_next   = 7'd1;
                                mode_next = MODE_LIT;
                            end
                            else
                            begin
                                mode_next = MODE_IDLE;
                            end
                            rl_next = '0;
                        end
                    end
                    MODE_LIT:
                    begin
                        if (state_reg == ST_CLOSE || stop)
                        begin
                            if (lc_reg != 7'd0)
                            begin
                                pend0_next    = HDR_LIT | {2'b00, lc_reg[5:0]};
                                pend_cnt_next = 2'd1;
                                lit_pend_next = 1'b1;
                                lit_len_next  = lc_reg;
                            end
                            lc_next   = '0;
                            mode_next = MODE_IDLE;
                            rl_next   = '0;
                        end
                        else
                        begin
                            done   = 1'b1;
                            ram_we = 1'b1;
                            if (lc_inc >= 7'(LITERAL_CHUNK))
                            begin
                                pend0_next    = HDR_LIT | {2'b00, lc_inc[5:0]};
                                pend_cnt_next = 2'd1;
                                lit_pend_next = 1'b1;
                                lit_len_next  = lc_inc;
                                lc_next       = '0;
                            end
                            else
                            begin
                                lc_next = lc_inc;
                            end
                        end
                    end
                    default:
                    begin
                        if (state_reg == ST_STEP)
                        begin
                            done    = 1'b1;
                            rl_next = 8'd1;
                            if (b == 8'd0)
                            begin
                                mode_next = MODE_ZERO;
                            end
                            else if (h1 && n1 == b)
                            begin
                                mode_next = MODE_DUP;
                                rv_next   = b;
                            end
                            else
                            begin
                                mode_next = MODE_LIT;
                                rl_next   = '0;
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                lc_next   = 7'd1;
                            end
                        end
                    end
                endcase

                if (state_reg == ST_CLOSE)
                begin
                    target = (mode_reg == MODE_IDLE) ? ST_END : ST_CLOSE;
                end
                else if (done)
                begin
                    if ((k_reg + 2'd1) == cmd_reg.fill || !cmd_reg.row_end)
                    begin
                        target = cmd_reg.row_end ? ST_CLOSE : ST_END;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                        target = ST_STEP;
                    end
                end

                if (pend_cnt_next != 2'd0)
                begin
                    ret_next   = target;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = target;
                end
            end
            ST_EMIT:
            begin
                if (pend_cnt_reg != 2'd0)
                begin
                    emit_req = 1'b1;
                    if (emit_ok)
                    begin
                        pend0_next    = pend1_reg;
                        pend_cnt_next = pend_cnt_reg - 2'd1;
                    end
                end
                else if (lit_pend_reg)
                begin
                    lit_pend_next = 1'b0;
                    j_next        = '0;
                    state_next    = ST_LRD;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            ST_LRD:
            begin
                ram_re     = 1'b1;
                state_next = ST_LWR;
            end
            ST_LWR:
            begin
                emit_req  = 1'b1;
                emit_byte = ram_rdata;
                if (emit_ok)
                begin
                    if ((j_reg + 7'd1) == lit_len_reg)
                    begin
                        state_next = ret_reg;
                    end
                    else
                    begin
                        j_next     = j_reg + 7'd1;
                        state_next = ST_LRD;
                    end
                end
            end
            ST_END:
            begin
                // a full word is held until the step ends so its end flag is known
                if (pcount_reg == 4'(WORD_BYTES) || (cmd_reg.last && pcount_reg != 4'd0))
                begin
                    push_req = 1'b1;
                    push_eob = cmd_reg.last;
                    if (out_free)
                    begin
                        state_next = ST_POP;
                    end
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            default:
            begin
                state_next = ST_POP;
            end
        endcase
    end

    // packer and output register
    always_comb
    begin
        buf_next    = buf_reg;
        pcount_next = pcount_reg;
        ov_next     = ov_reg && out_stall;
        ow_next     = ow_reg;
        oc_next     = oc_reg;
        eob_next    = eob_reg;
        if (emit_req && emit_ok)
        begin
            if (pcount_reg == 4'(WORD_BYTES))
            begin
                ov_next     = 1'b1;
                ow_next     = buf_reg;
                oc_next     = pcount_reg;
                eob_next    = 1'b0;
                buf_next    = {emit_byte, 56'd0};
                pcount_next = 4'd1;
            end
            else
            begin
                buf_next    = buf_reg | ({emit_byte, 56'd0} >> {pcount_reg[2:0], 3'b000});
                pcount_next = pcount_reg + 4'd1;
            end
        end
        if (push_req && out_free)
        begin
            ov_next     = 1'b1;
            ow_next     = buf_reg;
            oc_next     = pcount_reg;
            eob_next    = push_eob;
            buf_next    = '0;
            pcount_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        pend0_reg   <= pend0_next;
        pend1_reg   <= pend1_next;
        lit_len_reg <= lit_len_next;
        ow_reg      <= ow_next;
        oc_reg      <= oc_next;
        eob_reg     <= eob_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_POP;
            ret_reg      <= ST_POP;
            mode_reg     <= MODE_IDLE;
            k_reg        <= '0;
            rv_reg       <= '0;
            rl_reg       <= '0;
            lc_reg       <= '0;
            j_reg        <= '0;
            pend_cnt_reg <= '0;
            lit_pend_reg <= 1'b0;
            buf_reg      <= '0;
            pcount_reg   <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            mode_reg     <= mode_next;
            k_reg        <= k_next;
            rv_reg       <= rv_next;
            rl_reg       <= rl_next;
            lc_reg       <= lc_next;
            j_reg        <= j_next;
            pend_cnt_reg <= pend_cnt_next;
            lit_pend_reg <= lit_pend_next;
            buf_reg      <= buf_next;
            pcount_reg   <= pcount_next;
            ov_reg       <= ov_next;
        end
    end
endmodule
`default_nettype wire

// File: design/row_run_length_encoder_unit.sv
// Row run-length encoder: raw image bytes in, encoded bytes out packed into
// words of WORD_BYTES bytes (first byte in bits 63:56, byte_count valid bytes,
// end_of_block on the last word of a buffer). row_bytes (reset 150, 0 means
// 65536) sets the row length; the user must write it through the cfg port
// only while idle, which the block does not enforce. The front end windows
// the input and takes one byte per cycle, while the queue has room, into a
// four-entry command queue; the back end works one command at a time: each
// input byte passes through the pop, step and finish states when runs
// continue, with one more step when a run closes and the next one opens.
// Header and run bytes leave from the emit state, which can wait on the
// output; a flushed literal chunk is read back from the literal store one
// entry at a time through a read state and a write state. A row end steps
// through every byte still in the window and then closes the open run.
`timescale 1ns / 1ps
`default_nettype none
module row_run_length_encoder_unit
    import rrle_pkg::*;
#(
    parameter int LITERAL_CHUNK = 64,
    parameter int ZERO_CHUNK    = 128,
    parameter int WORD_BYTES    = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_of_block,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      out_word,
    output logic [3:0]       byte_count,
    output logic             end_of_block
);
    logic [15:0] row_bytes_reg;
    logic        q_push, q_full, q_pop, q_empty;
    rrle_cmd_t   q_wdata, q_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= 16'd150;
        end
        else if (cfg_valid && cfg_ready)
        begin
            row_bytes_reg <= cfg_data;
        end
    end

    rrle_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .row_bytes     (row_bytes_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_of_block (last_of_block),
        .q_push        (q_push),
        .q_data        (q_wdata),
        .q_full        (q_full)
    );

    rrle_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    rrle_back #(
        .LITERAL_CHUNK (LITERAL_CHUNK),
        .ZERO_CHUNK    (ZERO_CHUNK),
        .WORD_BYTES    (WORD_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_word     (out_word),
        .byte_count   (byte_count),
        .end_of_block (end_of_block)
    );

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count != 4'd0) && (byte_count <= 4'(WORD_BYTES)))
        else $error("byte_count out of range");

    a_partial_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_count != 4'(WORD_BYTES)) |-> end_of_block)
        else $error("partial word before end of block");
`endif
endmodule
`default_nettype wire
